// ===== rtl/hsl_pkg.sv =====
// Shared types and constants for the hillshade pixel lighting block.
// Used by the top level, its port checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

   // Default height precision, Q0.HEIGHT_BITS
   localparam int HEIGHT_BITS_DEF = 16;

   localparam int COLOR_W   = 8;
   localparam int HEIGHT_W  = 16;
   localparam int CFG_W     = 16;
   localparam int CFG_IDX_W = 3;

   // Slope magnitude after gain (Q.19), squared-length radicand, root
   localparam int NRM_W  = 24;
   localparam int SQ_W   = 2 * NRM_W + 2;
   localparam int ROOT_W = SQ_W / 2;
   // Dot product (signed Q.33), positive dividend, diffuse, lighting
   localparam int DOT_W  = 42;
   localparam int DVD_W  = DOT_W - 1;
   localparam int DIFF_W = 16;
   localparam int LIT_W  = 32;
   localparam int CG_W   = COLOR_W + CFG_W;
   localparam int OUT_SHIFT = 41;

   // Normal y component is 2.0 in Q.19
   localparam int NY_SHIFT = 20;

   localparam logic [COLOR_W-1:0] RIVER_RED   = 8'd25;
   localparam logic [COLOR_W-1:0] RIVER_GREEN = 8'd60;
   localparam logic [COLOR_W-1:0] RIVER_BLUE  = 8'd140;
   localparam logic [COLOR_W-1:0] COLOR_MAX   = 8'd255;

   localparam logic [CFG_W-1:0] SLOPE_RST      = 16'd2048;
   localparam logic [CFG_W-1:0] AMBIENT_RST    = 16'd9830;
   localparam logic [CFG_W-1:0] LIGHT_X_RST    = 16'd0;
   localparam logic [CFG_W-1:0] LIGHT_Y_RST    = 16'd16384;
   localparam logic [CFG_W-1:0] LIGHT_Z_RST    = 16'd0;
   localparam logic [CFG_W-1:0] BRIGHTNESS_RST = 16'd4096;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_SLOPE_SCALE = 3'd0,
      CSR_AMBIENT     = 3'd1,
      CSR_LIGHT_X     = 3'd2,
      CSR_LIGHT_Y     = 3'd3,
      CSR_LIGHT_Z     = 3'd4,
      CSR_BRIGHTNESS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  base_red;
      logic [COLOR_W-1:0]  base_green;
      logic [COLOR_W-1:0]  base_blue;
      logic [HEIGHT_W-1:0] height_left;
      logic [HEIGHT_W-1:0] height_right;
      logic [HEIGHT_W-1:0] height_down;
      logic [HEIGHT_W-1:0] height_up;
      logic                is_river;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] out_red;
      logic [COLOR_W-1:0] out_green;
      logic [COLOR_W-1:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

endpackage

`default_nettype wire

// ===== rtl/hillshade_pixel_lighting.sv =====
// Top level of the hillshade pixel lighting pipeline.
// Depends on hsl_pkg for request/response types and fixed-point widths.
`timescale 1ns / 1ps
`default_nettype none

// Shades one map pixel per clock while no response is held. A request can
// enter every such cycle and passes 4 front stages for slope, squares and dot
// product, 25 square-root stages producing one root bit each, 16 divider
// stages producing one diffuse bit each, 2 lighting stages and the output
// register. The whole pipeline holds while a response waits under rsp_stall.
// The user must write registers through the csr_ port while no request is in
// flight; the block itself does not enforce this.
module hillshade_pixel_lighting
   import hsl_pkg::*;
#(
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CFG_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int PW = HEIGHT_BITS + CFG_W;

   logic adv;

   logic [CFG_W-1:0] slope_ff, amb_ff, light_x_ff, light_y_ff, light_z_ff, gain_ff;

   // Advance the whole pipeline unless a finished response is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff   <= SLOPE_RST;
         amb_ff     <= AMBIENT_RST;
         light_x_ff <= LIGHT_X_RST;
         light_y_ff <= LIGHT_Y_RST;
         light_z_ff <= LIGHT_Z_RST;
         gain_ff    <= BRIGHTNESS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOPE_SCALE: slope_ff   <= csr_wdata;
            CSR_AMBIENT:     amb_ff     <= csr_wdata;
            CSR_LIGHT_X:     light_x_ff <= csr_wdata;
            CSR_LIGHT_Y:     light_y_ff <= csr_wdata;
            CSR_LIGHT_Z:     light_z_ff <= csr_wdata;
            CSR_BRIGHTNESS:  gain_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: height differences, color select
   logic [HEIGHT_BITS-1:0] hl, hr, hd, hu, mag_x_in, mag_z_in;
   logic                   neg_x_in, neg_z_in;
   color_type              col1_in;

   logic [HEIGHT_BITS-1:0] mag_x_ff, mag_z_ff;
   logic                   neg_x1_ff, neg_z1_ff, v1_ff;
   color_type              col1_ff;

   assign hl = HEIGHT_BITS'(req_data.height_left);
   assign hr = HEIGHT_BITS'(req_data.height_right);
   assign hd = HEIGHT_BITS'(req_data.height_down);
   assign hu = HEIGHT_BITS'(req_data.height_up);

   always_comb begin
      neg_x_in = hr > hl;
      mag_x_in = neg_x_in ? hr - hl : hl - hr;
      neg_z_in = hu > hd;
      mag_z_in = neg_z_in ? hu - hd : hd - hu;
      if (req_data.is_river) begin
         col1_in = '{red: RIVER_RED, green: RIVER_GREEN, blue: RIVER_BLUE};
      end else begin
         col1_in = '{red: req_data.base_red, green: req_data.base_green,
                     blue: req_data.base_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_x_ff  <= mag_x_in;
         mag_z_ff  <= mag_z_in;
         neg_x1_ff <= neg_x_in;
         neg_z1_ff <= neg_z_in;
         col1_ff   <= col1_in;
      end
   end

   // ---------------- stage 2: apply slope gain
   logic [PW-1:0]    prod_x, prod_z;
   logic [NRM_W-1:0] tx_ff, tz_ff;
   logic             neg_x2_ff, neg_z2_ff, v2_ff;
   color_type        col2_ff;

   assign prod_x = PW'(mag_x_ff) * PW'(slope_ff);
   assign prod_z = PW'(mag_z_ff) * PW'(slope_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff     <= NRM_W'(prod_x >> (HEIGHT_BITS - 8));
         tz_ff     <= NRM_W'(prod_z >> (HEIGHT_BITS - 8));
         neg_x2_ff <= neg_x1_ff;
         neg_z2_ff <= neg_z1_ff;
         col2_ff   <= col1_ff;
      end
   end

   // ---------------- stage 3: squares and light products
   logic signed [NRM_W:0]       nx_s, nz_s;
   logic signed [NRM_W+CFG_W:0] dx_ff, dz_ff;
   logic [2*NRM_W-1:0]          sqx_ff, sqz_ff;
   logic                        v3_ff;
   color_type                   col3_ff;

   assign nx_s = neg_x2_ff ? -$signed({1'b0, tx_ff}) : $signed({1'b0, tx_ff});
   assign nz_s = neg_z2_ff ? -$signed({1'b0, tz_ff}) : $signed({1'b0, tz_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff  <= (2*NRM_W)'(tx_ff) * (2*NRM_W)'(tx_ff);
         sqz_ff  <= (2*NRM_W)'(tz_ff) * (2*NRM_W)'(tz_ff);
         dx_ff   <= nx_s * $signed(light_x_ff);
         dz_ff   <= nz_s * $signed(light_z_ff);
         col3_ff <= col2_ff;
      end
   end

   // ---------------- stage 4: sum of squares and dot product
   logic [SQ_W-1:0]         sq_in;
   logic signed [DOT_W-1:0] s_in;
   logic [DVD_W-1:0]        dvd_in;
   logic [SQ_W-1:0]         sq4_ff;
   logic [DVD_W-1:0]        dvd4_ff;
   logic                    v4_ff;
   color_type               col4_ff;

   always_comb begin
      sq_in  = SQ_W'(sqx_ff) + SQ_W'(sqz_ff) + (SQ_W'(1) << (2 * NY_SHIFT));
      s_in   = DOT_W'(dx_ff) + DOT_W'(dz_ff)
               + (DOT_W'($signed(light_y_ff)) <<< NY_SHIFT);
      // Drop a non-positive dot product: diffuse becomes zero
      dvd_in = (!s_in[DOT_W-1] && (s_in != '0)) ? DVD_W'(s_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq4_ff  <= sq_in;
         dvd4_ff <= dvd_in;
         col4_ff <= col3_ff;
      end
   end

   // ---------------- square root: one root bit per stage
   logic [SQ_W-1:0]     rad_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [ROOT_W+1:0]   rem_ff  [ROOT_W];
   logic [DVD_W-1:0]    sdvd_ff [ROOT_W];
   color_type           scol_ff [ROOT_W];
   logic [ROOT_W-1:0]   sv_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [SQ_W-1:0]   rad_p;
      logic [ROOT_W-1:0] root_p;
      logic [ROOT_W+1:0] rem_p, rem_sh, trial;
      logic [DVD_W-1:0]  dvd_p;
      color_type         col_p;
      logic              v_p, ge;

      if (k == 0) begin : g_head
         assign rad_p  = sq4_ff;
         assign root_p = '0;
         assign rem_p  = '0;
         assign dvd_p  = dvd4_ff;
         assign col_p  = col4_ff;
         assign v_p    = v4_ff;
      end else begin : g_body
         assign rad_p  = rad_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign dvd_p  = sdvd_ff[k-1];
         assign col_p  = scol_ff[k-1];
         assign v_p    = sv_ff[k-1];
      end

      assign rem_sh = {rem_p[ROOT_W-1:0], rad_p[SQ_W-1 -: 2]};
      assign trial  = {root_p, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (adv) begin
            sv_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_p << 2;
            root_ff[k] <= {root_p[ROOT_W-2:0], ge};
            rem_ff[k]  <= ge ? rem_sh - trial : rem_sh;
            sdvd_ff[k] <= dvd_p;
            scol_ff[k] <= col_p;
         end
      end
   end

   // ---------------- divider: one diffuse bit per stage
   logic [ROOT_W-1:0]   drem_ff [DIFF_W];
   logic [DIFF_W-1:0]   dlow_ff [DIFF_W];
   logic [DIFF_W-1:0]   dq_ff   [DIFF_W];
   logic [ROOT_W-1:0]   dlen_ff [DIFF_W];
   color_type           dcol_ff [DIFF_W];
   logic [DIFF_W-1:0]   dv_ff;

   for (genvar j = 0; j < DIFF_W; j++) begin : g_div
      logic [ROOT_W-1:0] rem_p, len_p;
      logic [DIFF_W-1:0] low_p, q_p;
      logic [ROOT_W:0]   r2;
      color_type         col_p;
      logic              v_p, ge;

      if (j == 0) begin : g_head
         // Quotient stays below 2^16, so the upper dividend is below the root
         assign rem_p = sdvd_ff[ROOT_W-1][DVD_W-1:DIFF_W];
         assign low_p = sdvd_ff[ROOT_W-1][DIFF_W-1:0];
         assign q_p   = '0;
         assign len_p = root_ff[ROOT_W-1];
         assign col_p = scol_ff[ROOT_W-1];
         assign v_p   = sv_ff[ROOT_W-1];
      end else begin : g_body
         assign rem_p = drem_ff[j-1];
         assign low_p = dlow_ff[j-1];
         assign q_p   = dq_ff[j-1];
         assign len_p = dlen_ff[j-1];
         assign col_p = dcol_ff[j-1];
         assign v_p   = dv_ff[j-1];
      end

      assign r2 = {rem_p, low_p[DIFF_W-1]};
      assign ge = r2 >= {1'b0, len_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[j] <= ROOT_W'(ge ? r2 - {1'b0, len_p} : r2);
            dlow_ff[j] <= low_p << 1;
            dq_ff[j]   <= {q_p[DIFF_W-2:0], ge};
            dlen_ff[j] <= len_p;
            dcol_ff[j] <= col_p;
         end
      end
   end

   // ---------------- lighting stage 1: diffuse share, color times gain
   logic signed [CFG_W:0]     coef;
   logic signed [2*CFG_W+1:0] litp_ff;
   logic [CFG_W+13:0]         amb14_ff;
   logic [CG_W-1:0]           cg_r_ff, cg_g_ff, cg_b_ff;
   logic                      vl1_ff;

   assign coef = $signed({1'b0, 16'h8000}) - $signed({1'b0, amb_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vl1_ff <= 1'b0;
      end else if (adv) begin
         vl1_ff <= dv_ff[DIFF_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         litp_ff  <= coef * $signed({1'b0, dq_ff[DIFF_W-1]});
         amb14_ff <= {amb_ff, 14'b0};
         cg_r_ff  <= CG_W'(dcol_ff[DIFF_W-1].red) * CG_W'(gain_ff);
         cg_g_ff  <= CG_W'(dcol_ff[DIFF_W-1].green) * CG_W'(gain_ff);
         cg_b_ff  <= CG_W'(dcol_ff[DIFF_W-1].blue) * CG_W'(gain_ff);
      end
   end

   // ---------------- lighting stage 2: add ambient, clamp at zero
   logic signed [2*CFG_W+2:0] lit_in;
   logic [LIT_W-1:0]          light_ff;
   logic [CG_W-1:0]           cg2_r_ff, cg2_g_ff, cg2_b_ff;
   logic                      vl2_ff;

   assign lit_in = (2*CFG_W+3)'(litp_ff) + $signed({5'b0, amb14_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vl2_ff <= 1'b0;
      end else if (adv) begin
         vl2_ff <= vl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         light_ff <= lit_in[2*CFG_W+2] ? '0 : LIT_W'(lit_in);
         cg2_r_ff <= cg_r_ff;
         cg2_g_ff <= cg_g_ff;
         cg2_b_ff <= cg_b_ff;
      end
   end

   // ---------------- output stage: scale, truncate, saturate
   localparam int FW = CG_W + LIT_W;

   logic [FW-1:0]                p_r, p_g, p_b;
   logic [FW-OUT_SHIFT-1:0]      h_r, h_g, h_b;
   rsp_type                      rsp_ff;
   logic                         vo_ff;

   assign p_r = FW'(cg2_r_ff) * FW'(light_ff);
   assign p_g = FW'(cg2_g_ff) * FW'(light_ff);
   assign p_b = FW'(cg2_b_ff) * FW'(light_ff);
   assign h_r = p_r[FW-1:OUT_SHIFT];
   assign h_g = p_g[FW-1:OUT_SHIFT];
   assign h_b = p_b[FW-1:OUT_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= vl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.out_red   <= (h_r > (FW-OUT_SHIFT)'(COLOR_MAX)) ? COLOR_MAX : COLOR_W'(h_r);
         rsp_ff.out_green <= (h_g > (FW-OUT_SHIFT)'(COLOR_MAX)) ? COLOR_MAX : COLOR_W'(h_g);
         rsp_ff.out_blue  <= (h_b > (FW-OUT_SHIFT)'(COLOR_MAX)) ? COLOR_MAX : COLOR_W'(h_b);
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/hsl_checker.sv =====
// Port-level checker for hillshade_pixel_lighting, bound to the top level.
// Depends on hsl_pkg for the response type.
`timescale 1ns / 1ps
`default_nettype none

module hsl_checker
   import hsl_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Pipeline comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Request side only stalls behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall without a held response");

   // A held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

endmodule

bind hillshade_pixel_lighting hsl_checker u_hsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the hillshade pixel lighting block.
// Depends on hsl_pkg and hillshade_pixel_lighting; it predicts every response.
`timescale 1ns / 1ps

module tb_top
   import hsl_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int REQ_W          = $bits(req_type);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // Shadow copy of the lighting registers
   logic [CFG_W-1:0] slope_gain, ambient_share, light_x, light_y, light_z, bright_gain;

   rsp_type pixel_queue[$];
   int      mismatch_count = 0;
   int      pixels_sent = 0;
   int      pixels_shaded = 0;
   int      river_pixels = 0;
   int      config_writes = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   hillshade_pixel_lighting u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Floor square root, one result bit per pass
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Signed slope component in Q.19 from two neighbor heights
   function automatic longint height_slope(logic [HEIGHT_W-1:0] a, logic [HEIGHT_W-1:0] b);
      longint unsigned mag;
      longint unsigned t;
      mag = (b > a) ? longint'(b) - longint'(a) : longint'(a) - longint'(b);
      t = (mag * longint'(slope_gain)) >> (HEIGHT_BITS_DEF - 8);
      return (b > a) ? -longint'(t) : longint'(t);
   endfunction

   function automatic logic [COLOR_W-1:0] lit_channel(logic [COLOR_W-1:0] c,
                                                      longint unsigned lighting);
      longint unsigned v;
      v = (longint'(c) * lighting * longint'(bright_gain)) >> OUT_SHIFT;
      return (v > 255) ? COLOR_MAX : v[COLOR_W-1:0];
   endfunction

   function automatic rsp_type shade_pixel(req_type px);
      longint nx, nz, ny, dot, diffuse, amb, lit;
      longint unsigned len, lighting;
      color_type c;
      rsp_type r;
      nx = height_slope(px.height_left, px.height_right);
      nz = height_slope(px.height_down, px.height_up);
      ny = longint'(1) << NY_SHIFT;
      len = floor_root(longint'(nx * nx) + longint'(ny * ny) + longint'(nz * nz));
      dot = nx * longint'($signed(light_x)) + ny * longint'($signed(light_y))
          + nz * longint'($signed(light_z));
      diffuse = 0;
      if (dot > 0 && len != 0) diffuse = longint'(longint'(unsigned'(dot)) / len);
      amb = longint'(ambient_share);
      lit = amb * 16384 + (32768 - amb) * diffuse;
      lighting = (lit > 0) ? longint'(lit) : 0;
      c = '{px.base_red, px.base_green, px.base_blue};
      if (px.is_river) c = '{RIVER_RED, RIVER_GREEN, RIVER_BLUE};
      r.out_red = lit_channel(c.red, lighting);
      r.out_green = lit_channel(c.green, lighting);
      r.out_blue = lit_channel(c.blue, lighting);
      return r;
   endfunction

   // Randomize the stall for the next edge
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_shaded++;
         if (pixel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h with nothing predicted", rsp_data);
         end else begin
            want = pixel_queue.pop_front();
            if (want.out_red !== rsp_data.out_red || want.out_green !== rsp_data.out_green
                || want.out_blue !== rsp_data.out_blue) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                           want.out_red, want.out_green, want.out_blue,
                           rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue);
            end
         end
      end
   end

   // Stop when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request, hold it until accepted, predict its response
   task automatic send_pixel(req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = px;
      do @(posedge clock); while (req_stall);
      pixel_queue.push_back(shade_pixel(px));
      pixels_sent++;
      if (px.is_river) river_pixels++;
      @(negedge clock);
   endtask

   task automatic finish_stream();
      req_valid = 1'b0;
   endtask

   // Hold until every prediction has been matched and the pipe is empty
   task automatic drain();
      finish_stream();
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_SLOPE_SCALE: slope_gain = val;
         CSR_AMBIENT:     ambient_share = val;
         CSR_LIGHT_X:     light_x = val;
         CSR_LIGHT_Y:     light_y = val;
         CSR_LIGHT_Z:     light_z = val;
         CSR_BRIGHTNESS:  bright_gain = val;
         default: ;
      endcase
      config_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_lighting(logic [CFG_W-1:0] slope, logic [CFG_W-1:0] amb,
                               logic [CFG_W-1:0] lx, logic [CFG_W-1:0] ly,
                               logic [CFG_W-1:0] lz, logic [CFG_W-1:0] gain);
      drain();
      write_reg(CSR_SLOPE_SCALE, slope);
      write_reg(CSR_AMBIENT, amb);
      write_reg(CSR_LIGHT_X, lx);
      write_reg(CSR_LIGHT_Y, ly);
      write_reg(CSR_LIGHT_Z, lz);
      write_reg(CSR_BRIGHTNESS, gain);
   endtask

   function automatic req_type make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [15:0] hl, logic [15:0] hr,
                                          logic [15:0] hd, logic [15:0] hu, logic river);
      req_type px;
      px = '{r, g, b, hl, hr, hd, hu, river};
      return px;
   endfunction

   // Mostly gentle terrain around a random height, some fully random pixels
   function automatic req_type random_pixel();
      req_type px;
      logic [15:0] base;
      int spread;
      px = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      px.is_river = ($urandom_range(99) < 20);
      if ($urandom_range(99) < 70) begin
         spread = ($urandom_range(1)) ? 64 : 2048;
         base = HEIGHT_W'($urandom_range(65535 - spread, spread));
         px.height_left = HEIGHT_W'(base + $urandom_range(spread) - spread / 2);
         px.height_right = HEIGHT_W'(base + $urandom_range(spread) - spread / 2);
         px.height_down = HEIGHT_W'(base + $urandom_range(spread) - spread / 2);
         px.height_up = HEIGHT_W'(base + $urandom_range(spread) - spread / 2);
      end
      return px;
   endfunction

   function automatic logic [CFG_W-1:0] random_dir();
      return CFG_W'($urandom_range(32768) - 16384);
   endfunction

   task automatic random_pixels(int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // Extremes of color, height and river flag under the reset lighting
   task automatic test_extremes();
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd128, 8'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0));
      send_pixel(make_pixel(8'd10, 8'd200, 8'd77, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 1'b1));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 16'h1234, 16'h1200, 16'h8000, 16'h7FFF, 1'b1));
   endtask

   // Ambient above one, unnormalized light, out of range gains, stray index
   task automatic test_special_cases();
      set_lighting(16'd2048, 16'hFFFF, 16'd0, 16'd16384, 16'd0, 16'd4096);
      send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 16'd0, 16'hFFFF, 16'd100, 16'd0, 1'b0));
      send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 16'd500, 16'd500, 16'd0, 16'd0, 1'b1));
      set_lighting(16'hFFFF, 16'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_pixel(make_pixel(8'd30, 8'd90, 8'd250, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b0));
      send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 16'd100, 16'd90, 16'd5, 16'd9, 1'b0));
      set_lighting(16'd40960, 16'd32768, -16'sd16384, 16'd0, 16'd16384, 16'd0);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 16'd7, 16'd9000, 16'd3, 16'd3, 1'b0));
      drain();
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, 16'h0000);
      send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 16'd7, 16'd9000, 16'd3, 16'd3, 1'b1));
      set_lighting(16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd4096);
      send_pixel(make_pixel(8'd255, 8'd64, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0));
   endtask

   // Several lighting setups with random pixels; each setup and one extra pause wait for an empty pipe
   task automatic test_random_phase(int count);
      set_lighting(16'd2048, 16'd9830, 16'd0, 16'd16384, 16'd0, 16'd4096);
      random_pixels(count / 4);
      drain();
      random_pixels(count / 4);
      set_lighting(CFG_W'($urandom_range(40960)), CFG_W'($urandom_range(32768)),
                   random_dir(), random_dir(), random_dir(),
                   CFG_W'($urandom_range(65535)));
      random_pixels(count / 4);
      set_lighting(CFG_W'($urandom_range(40960)), CFG_W'($urandom_range(32768)),
                   16'd9459, 16'd9459, 16'd9459, CFG_W'($urandom_range(8192, 2048)));
      random_pixels(count - 3 * (count / 4));
   endtask

   initial begin
      slope_gain = SLOPE_RST;
      ambient_share = AMBIENT_RST;
      light_x = LIGHT_X_RST;
      light_y = LIGHT_Y_RST;
      light_z = LIGHT_Z_RST;
      bright_gain = BRIGHTNESS_RST;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_special_cases();

      send_idle_pct = 6;
      recv_stall_pct = 73;
      test_random_phase(650);
      send_idle_pct = 73;
      recv_stall_pct = 6;
      test_random_phase(650);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_phase(650);
      drain();

      $display("Shaded %0d pixels (%0d river) across %0d register writes,",
               pixels_sent, river_pixels, config_writes);
      $display("with both sides stalling in turn and %0d responses checked.",
               pixels_shaded);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
